/* hdl/rgb_3x3_convolution_filter_top_assert.svh */
// assertion macros shared by the filter checker
`ifndef RGB_3X3_CONVOLUTION_FILTER_TOP_ASSERT_SVH
`define RGB_3X3_CONVOLUTION_FILTER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RGB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("filter checker: implication failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define RGB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("filter checker: next-cycle implication failed");

`endif

/* hdl/rgbconv_pkg.sv */
// types, constants and kernel arithmetic of the rgb 3x3 convolution filter
package rgbconv_pkg;

  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int LINE_W    = 2 * PIX_W;
  localparam int COORD_W   = 11;
  localparam int MODE_W    = 2;
  localparam int IMG_W     = 12;
  localparam int ACC_W     = 13;
  localparam int SUM_W     = 12;
  localparam int CFG_W     = 32;
  localparam int ADDR_W    = 3;
  localparam int RECIP_W   = 13;
  localparam int BLUR_SHFT = 16;

  localparam logic [IMG_W-1:0]   WIDTH_RST  = 12'd2048;
  // floor(n * 7282 / 2^16) == floor(n / 9) for every n up to 9 * 255
  localparam logic [RECIP_W-1:0] BLUR_RECIP = 13'd7282;

  typedef enum logic [MODE_W-1:0] {
    MODE_EDGE    = 2'd0,
    MODE_SHARPEN = 2'd1,
    MODE_BLUR    = 2'd2
  } mode_e;

  typedef enum logic {
    REG_MODE  = 1'b0,
    REG_WIDTH = 1'b1
  } reg_idx_e;

  // neighborhood of one channel, index is row * 3 + column
  typedef logic [8:0][CH_W-1:0] nbhd_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  function automatic acc_t kernel_acc(input nbhd_t nb, input logic [MODE_W-1:0] mode);
    logic [SUM_W-1:0] s01, s23, s45, s67, sum;
    logic [SUM_W-1:0] cross_sum;
    acc_t             ctr;
    acc_t             res;
    s01   = SUM_W'(nb[0]) + SUM_W'(nb[1]);
    s23   = SUM_W'(nb[2]) + SUM_W'(nb[3]);
    s45   = SUM_W'(nb[4]) + SUM_W'(nb[5]);
    s67   = SUM_W'(nb[6]) + SUM_W'(nb[7]);
    sum   = (s01 + s23) + (s45 + s67) + SUM_W'(nb[8]);
    cross_sum = (SUM_W'(nb[1]) + SUM_W'(nb[3])) + (SUM_W'(nb[5]) + SUM_W'(nb[7]));
    ctr   = signed'(ACC_W'(nb[4]));
    case (mode)
      MODE_SHARPEN: res = ctr * 13'sd5 - signed'(ACC_W'(cross_sum));
      MODE_BLUR:    res = signed'(ACC_W'(sum));
      default:      res = ctr * 13'sd9 - signed'(ACC_W'(sum));
    endcase
    return res;
  endfunction

  function automatic logic [CH_W-1:0] kernel_out(input acc_t acc, input logic blur);
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [CH_W-1:0]          res;
    prod = (SUM_W+RECIP_W)'(acc[SUM_W-1:0]) * (SUM_W+RECIP_W)'(BLUR_RECIP);
    if (blur) begin
      res = prod[BLUR_SHFT +: CH_W];
    end else if (acc < 0) begin
      res = '0;
    end else if (acc > 13'sd255) begin
      res = '1;
    end else begin
      res = acc[CH_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hdl/rgbconv_ram.sv */
// generic single-clock ram, one write port, one registered read port
module rgbconv_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                   wdata_i,
  input  logic                               re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                   rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rgb_3x3_convolution_filter_top.sv */
// rgb 3x3 convolution filter: line store ram, window, kernel and output stages
//
// Pixels enter in raster order on the in_* channel, one beat per pixel;
// frame_start_i on a beat marks column 0, row 0 of a new image. For each
// input pixel at column >= 2, row >= 2, closing a 3x3 neighborhood, one beat
// leaves on the out_* channel carrying the center coordinate and the three
// clamped filtered channels; border pixels produce no beat.
// Both line stores share one ram (upper row and lower row side by side),
// read at the pixel's column when the beat is accepted, written back when it
// leaves stage 1; a back-to-back access to the same column is forwarded.
// Throughput: one pixel per cycle while out_stall_i is low. A beat passes
// the ram read, kernel sums, and divide and clamp stages in that order.
// When out_stall_i is high the output beat holds, the two inner stages fill,
// and in_stall_o rises only once all of them hold a result.
// Reset clears the counters, window and stage valids at once; there is no
// ram clearing pass; stale words read in rows 0 and 1 reach no output beat.
// Configuration (kernel mode at 0x0, image width at 0x4) must be written
// over the apb port while no beat is in flight; the block does not enforce it.
module rgb_3x3_convolution_filter_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rgbconv_pkg::ADDR_W-1:0]    paddr,
  input  logic [rgbconv_pkg::CFG_W-1:0]     pwdata,
  output logic [rgbconv_pkg::CFG_W-1:0]     prdata,
  output logic                              pready,
  // input pixels
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rgbconv_pkg::CH_W-1:0]      red_in_i,
  input  logic [rgbconv_pkg::CH_W-1:0]      green_in_i,
  input  logic [rgbconv_pkg::CH_W-1:0]      blue_in_i,
  input  logic                              frame_start_i,
  // filtered pixels
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rgbconv_pkg::COORD_W-1:0]   center_col_o,
  output logic [rgbconv_pkg::COORD_W-1:0]   center_row_o,
  output logic [rgbconv_pkg::CH_W-1:0]      red_out_o,
  output logic [rgbconv_pkg::CH_W-1:0]      green_out_o,
  output logic [rgbconv_pkg::CH_W-1:0]      blue_out_o
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WW > rgbconv_pkg::IMG_W) ? WW : rgbconv_pkg::IMG_W;
  localparam int PW  = rgbconv_pkg::PIX_W;
  localparam int CHW = rgbconv_pkg::CH_W;

  // configuration registers
  logic [rgbconv_pkg::MODE_W-1:0] mode_q;
  logic [rgbconv_pkg::IMG_W-1:0]  width_q;
  logic                           cfg_wr;
  logic [EW-1:0]                  img_ext;
  logic [EW-1:0]                  eff_w;

  // position counters
  logic [CW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_n, c0;
  logic [RW-1:0] row_n, r0;
  logic [EW-1:0] c1;
  logic          prod_n;

  // handshake
  logic in_acc, s1_leave, s2_leave, rdy2, rdy_o;

  // stage 1: ram read in flight
  logic          s1_v_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic [PW-1:0] s1_pix_q;
  logic          s1_prod_q;
  logic          s1_haz_q;
  logic [rgbconv_pkg::LINE_W-1:0] s1_fwd_q;
  logic [rgbconv_pkg::LINE_W-1:0] ram_rdata, rd_line;
  logic [PW-1:0] top_px, mid_px;
  logic          haz_n;

  // window, previous two columns of the three-row band
  logic [5:0][PW-1:0] win_q;
  logic [8:0][PW-1:0] nb_pix;
  rgbconv_pkg::nbhd_t [2:0] nb_ch;
  rgbconv_pkg::acc_t  [2:0] acc_n;

  // stage 2: kernel sums
  logic                     s2_v_q;
  rgbconv_pkg::acc_t  [2:0] s2_acc_q;
  logic                     s2_blur_q;
  logic [rgbconv_pkg::COORD_W-1:0] s2_col_q, s2_row_q;

  // output register
  logic                     out_v_q;
  logic [2:0][CHW-1:0]      out_rgb_q;
  logic [rgbconv_pkg::COORD_W-1:0] out_col_q, out_row_q;

  // ---------------- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == rgbconv_pkg::REG_WIDTH) ? rgbconv_pkg::CFG_W'(width_q)
                                                       : rgbconv_pkg::CFG_W'(mode_q);

  always_comb begin
    img_ext = EW'(width_q);
    if (img_ext < EW'(3)) begin
      eff_w = EW'(3);
    end else if (img_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = img_ext;
    end
  end

  // ---------------- handshake
  assign rdy_o      = !out_v_q || !out_stall_i;
  assign rdy2       = !s2_v_q || rdy_o;
  assign s2_leave   = s2_v_q && rdy_o;
  assign s1_leave   = s1_v_q && (!s1_prod_q || rdy2);
  assign in_stall_o = s1_v_q && !s1_leave;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------- position of the incoming pixel and of the next one
  always_comb begin
    c0 = frame_start_i ? '0 : cnt_q;
    r0 = frame_start_i ? '0 : row_q;
    // width shrunk under a partial row: start a new row
    if (EW'(c0) >= eff_w) begin
      c0 = '0;
      if (r0 < RW'(MAX_HEIGHT - 1)) begin
        r0 = r0 + RW'(1);
      end
    end
    col_n  = c0;
    row_n  = r0;
    prod_n = (c0 >= CW'(2)) && (r0 >= RW'(2));
    c1     = EW'(c0) + EW'(1);
    if (c1 >= eff_w) begin
      cnt_d = '0;
      row_d = (r0 < RW'(MAX_HEIGHT - 1)) ? r0 + RW'(1) : r0;
    end else begin
      cnt_d = CW'(c1);
      row_d = r0;
    end
  end

  // ---------------- line stores, upper row in the high half
  assign rd_line = s1_haz_q ? s1_fwd_q : ram_rdata;
  assign top_px  = rd_line[rgbconv_pkg::LINE_W-1:PW];
  assign mid_px  = rd_line[PW-1:0];
  // the item leaving stage 1 writes the column the new item reads
  assign haz_n   = s1_leave && (s1_col_q == col_n);

  rgbconv_ram #(
    .WIDTH (rgbconv_pkg::LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_leave),
    .waddr_i (s1_col_q),
    .wdata_i ({mid_px, s1_pix_q}),
    .re_i    (in_acc),
    .raddr_i (col_n),
    .rdata_o (ram_rdata)
  );

  // ---------------- kernel sums
  always_comb begin
    nb_pix[0] = win_q[0];
    nb_pix[1] = win_q[3];
    nb_pix[2] = top_px;
    nb_pix[3] = win_q[1];
    nb_pix[4] = win_q[4];
    nb_pix[5] = mid_px;
    nb_pix[6] = win_q[2];
    nb_pix[7] = win_q[5];
    nb_pix[8] = s1_pix_q;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        nb_ch[ch][k] = nb_pix[k][(2 - ch) * CHW +: CHW];
      end
      acc_n[ch] = rgbconv_pkg::kernel_acc(nb_ch[ch], mode_q);
    end
  end

  // ---------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= rgbconv_pkg::MODE_EDGE;
      width_q <= rgbconv_pkg::WIDTH_RST;
      cnt_q   <= '0;
      row_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      win_q   <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == rgbconv_pkg::REG_WIDTH) begin
          width_q <= pwdata[rgbconv_pkg::IMG_W-1:0];
        end else begin
          mode_q <= pwdata[rgbconv_pkg::MODE_W-1:0];
        end
      end
      if (in_acc) begin
        cnt_q <= cnt_d;
        row_q <= row_d;
      end
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_leave) begin
        s1_v_q <= 1'b0;
      end
      if (s1_leave && s1_prod_q) begin
        s2_v_q <= 1'b1;
      end else if (s2_leave) begin
        s2_v_q <= 1'b0;
      end
      if (s2_leave) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (s1_leave) begin
        win_q <= {s1_pix_q, mid_px, top_px, win_q[5], win_q[4], win_q[3]};
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q  <= col_n;
      s1_row_q  <= row_n;
      s1_pix_q  <= {red_in_i, green_in_i, blue_in_i};
      s1_prod_q <= prod_n;
      s1_haz_q  <= haz_n;
      s1_fwd_q  <= {mid_px, s1_pix_q};
    end
    if (s1_leave && s1_prod_q) begin
      s2_acc_q  <= acc_n;
      s2_blur_q <= (mode_q == rgbconv_pkg::MODE_BLUR);
      s2_col_q  <= rgbconv_pkg::COORD_W'(s1_col_q - CW'(1));
      s2_row_q  <= rgbconv_pkg::COORD_W'(s1_row_q - RW'(1));
    end
    if (s2_leave) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_rgb_q[ch] <= rgbconv_pkg::kernel_out(s2_acc_q[ch], s2_blur_q);
      end
      out_col_q <= s2_col_q;
      out_row_q <= s2_row_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign center_col_o = out_col_q;
  assign center_row_o = out_row_q;
  assign red_out_o    = out_rgb_q[0];
  assign green_out_o  = out_rgb_q[1];
  assign blue_out_o   = out_rgb_q[2];

endmodule

/* hdl/rgbconv_checker.sv */
// port-level checker for the rgb 3x3 convolution filter, bound to the top level
`include "rgb_3x3_convolution_filter_top_assert.svh"

module rgbconv_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [rgbconv_pkg::COORD_W-1:0] center_col_o,
  input logic [rgbconv_pkg::COORD_W-1:0] center_row_o,
  input logic [rgbconv_pkg::CH_W-1:0]    red_out_o,
  input logic [rgbconv_pkg::CH_W-1:0]    green_out_o,
  input logic [rgbconv_pkg::CH_W-1:0]    blue_out_o
);

  // a stalled output beat stays
  `RGB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // and its payload does not move
  `RGB_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(center_col_o) && $stable(center_row_o) && $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o))

  // input backpressure only while a full output beat is held off
  `RGB_ASSERT_IMPLY(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // pixels of column 0 and row 0 never come out as centers
  `RGB_ASSERT_IMPLY(a_no_border, out_valid_o, center_col_o != 0 && center_row_o != 0)

endmodule

bind rgb_3x3_convolution_filter_top rgbconv_checker u_rgbconv_checker (.*);
